[rtl/sha256_pkg.sv]
// shared types, constants and functions of the sha-256 byte stream hasher
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int WordW = 32;
  localparam int BlockBytes = 64;
  localparam int PadLimit = 56;
  localparam int TotalW = 61;
  localparam logic [7:0] PadMark = 8'h80;

  typedef logic [WordW-1:0] word_t;

  // datapath commands from the controller
  typedef struct packed {
    logic        put;        // write put_byte at fill position
    logic [7:0]  put_byte;
    logic        count_byte; // bump message length
    logic        start;      // load working words from the chain, clear round counter
    logic        round;      // run one round
    logic        fold;       // add working words into chain
    logic        clear;      // back to initial state
    logic        load_out;   // latch digest word at out_sel
    logic [2:0]  out_sel;
  } sha256_cmd_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [5:0]  round_idx;
    logic [63:0] bit_len;
  } sha256_stat_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85; 3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a; 3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

[rtl/sha256_if.sv]
// valid/ready channel interfaces for input bytes and digest words
`timescale 1ns / 1ps
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, byte_value, byte_present, end_of_message, input ready);
  modport sink (input valid, byte_value, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha256_datapath.sv]
// message schedule window (also the byte buffer of a block), round logic and chaining words
`timescale 1ns / 1ps
module sha256_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha256_pkg::sha256_cmd_t cmd,
  output sha256_pkg::sha256_stat_t stat,
  output logic [31:0]            out_word
);
  import sha256_pkg::*;

  word_t       w_r [16];
  word_t       v_r [8];
  word_t       h_r [8];
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [TotalW-1:0] total_r;
  word_t       out_r;

  word_t wr, g0, g1, s0, s1, ch, maj, t1, t2, wnew;

  // schedule and round function
  always_comb begin
    g0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    g1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + g0 + w_r[9] + g1;
    wr = (rnd_r < 6'd16) ? w_r[0] : wnew;
    s1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + round_k(rnd_r) + wr;
    s0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + maj;
  end

  // bytes go straight into the schedule words, big-endian within a word;
  // the window shifts by one word per round, slot 0 is the current word in the first 16 rounds
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wr;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (cmd.put) begin
      w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= cmd.put_byte;
    end
    if (cmd.load_out) out_r <= h_r[cmd.out_sel];
  end

  // control state: fill, length, round counter, chain
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      fill_r <= '0;
      total_r <= '0;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      if (cmd.put) fill_r <= fill_r + 6'd1;
      if (cmd.count_byte) total_r <= total_r + TotalW'(1);
      if (cmd.start) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign stat.fill = fill_r;
  assign stat.round_idx = rnd_r;
  assign stat.bit_len = {total_r, 3'b000};
  assign out_word = out_r;
endmodule

[rtl/sha256_ctrl.sv]
// controller: byte intake, padding sequence, compression and digest output
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  sha256_in_if.sink               in_ch,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_index,
  input  sha256_pkg::sha256_stat_t stat,
  output sha256_pkg::sha256_cmd_t  cmd
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FOLD, S_PAD, S_LOAD, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic       fin_r, fin_nxt;
  logic       mark_r, mark_nxt;
  logic       len_ok_r, len_ok_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [5:0] len_pos;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_index = idx_r;
  assign len_pos = stat.fill - 6'(PadLimit);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r;
    mark_nxt = mark_r;
    len_ok_nxt = len_ok_r;
    ovalid_nxt = ovalid_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.out_sel = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd.put = in_ch.byte_present;
          cmd.put_byte = in_ch.byte_value;
          cmd.count_byte = in_ch.byte_present;
          fin_nxt = in_ch.end_of_message;
          mark_nxt = 1'b0;
          len_ok_nxt = 1'b0;
          // a full block compresses first, padding follows after the fold
          if (in_ch.byte_present && stat.fill == 6'd63) state_nxt = S_START;
          else if (in_ch.end_of_message) state_nxt = S_PAD;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.round_idx == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!fin_r) state_nxt = S_IDLE;
        else if (len_ok_r) begin
          state_nxt = S_LOAD;
          idx_nxt = '0;
        end else begin
          // a fresh block after the mark always has room for the length
          len_ok_nxt = 1'b1;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.put = 1'b1;
        if (!mark_r) begin
          cmd.put_byte = PadMark;
          mark_nxt = 1'b1;
          len_ok_nxt = stat.fill < 6'(PadLimit);
        end else if (len_ok_r && stat.fill >= 6'(PadLimit))
          cmd.put_byte = stat.bit_len[{~len_pos[2:0], 3'b000} +: 8];
        else cmd.put_byte = 8'h00;
        if (stat.fill == 6'd63) state_nxt = S_START;
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          if (idx_r == 3'd7) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r <= 1'b0;
      ovalid_r <= 1'b0;
      idx_r <= '0;
      mark_r <= 1'b0;
      len_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r <= idx_nxt;
      mark_r <= mark_nxt;
      len_ok_r <= len_ok_nxt;
    end
  end
endmodule

[rtl/sha256_byte_stream_hasher.sv]
// top level of the sha-256 byte stream hasher
//
// usage: the input channel takes one item per handshake: a message byte
// (byte_present) and/or an end-of-message flag. bytes fill a 64-byte block;
// the 64th byte starts a compression (load, 64 rounds, fold), one round per
// cycle in a single shared round unit, during which in_ready is low. a
// plain byte otherwise leaves in_ready high.
// an end item pads the message a byte a cycle up to the block end, with one
// or two compressions, then emits eight digest items, word 0 first, each
// from an output register; word_index 7 carries last_word. each word is
// loaded into that register, then offered; a stalled receiver holds the word.
// after word 7 the chain, fill count and length return to their initial
// values. rst_n (synchronous, active low) restores the same initial state.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
  input logic        clk,
  input logic        rst_n,
  sha256_in_if.sink  in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  sha256_cmd_t  cmd;
  sha256_stat_t stat;
  logic [31:0]  word;
  logic [2:0]   idx;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_ch,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_index(idx),
    .stat, .cmd
  );

  sha256_datapath u_dp (.clk, .rst_n, .cmd, .stat, .out_word(word));

  // word index is advanced after the handshake, so register it beside the word
  logic [2:0] oidx_r;
  always_ff @(posedge clk) begin
    if (cmd.load_out) oidx_r <= idx;
  end

  assign out_ch.digest_word = word;
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word = (oidx_r == 3'd7);
endmodule
